// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

  // Coefficient and root formats
  localparam int COEF_W = 16;
  localparam int ROOT_W = 32;

  // Discriminant b*b - 4*a*c, signed
  localparam int DISC_W = 2 * COEF_W + 2;
  // Square root of disc << 16: result bits and radicand bits
  localparam int SQ_W   = COEF_W + 9;
  localparam int RAD_W  = 2 * SQ_W;
  // -b*256 +/- sqrt, signed
  localparam int SUM_W  = SQ_W + 2;
  // Dividend magnitude and divisor magnitude
  localparam int NUM_W  = SUM_W + 8;
  localparam int DEN_W  = COEF_W + 1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_TWO   = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_DEGEN = 2'd3
  } kind_t;

  // Classified request passed from front to back
  typedef struct packed {
    kind_t                     kind;
    logic                      lin;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
    logic signed [DISC_W-1:0]  disc;
  } qentry_t;

  // Fields riding along the square-root stages
  typedef struct packed {
    kind_t                     kind;
    logic                      lin;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
    logic signed [SUM_W-1:0]   nb;
  } sq_side_t;

  // Fields riding along the divider stages
  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
  } dv_side_t;

  // Apply sign to a quotient magnitude and clamp to the root range.
  // Returns {overflow, root}.
  function automatic logic [ROOT_W:0] fit_root(input logic [NUM_W-1:0] mag,
                                               input logic neg);
    logic [NUM_W+ROOT_W-1:0] m;
    logic [NUM_W+ROOT_W-1:0] lim;
    logic [ROOT_W-1:0]       val;
    logic                    ovf;
    m   = (NUM_W+ROOT_W)'(mag);
    lim = {{(NUM_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
    ovf = 1'b0;
    if (neg) begin
      if (m > lim + 1'b1) begin
        val = {1'b1, {(ROOT_W-1){1'b0}}};
        ovf = 1'b1;
      end else begin
        val = -m[ROOT_W-1:0];
      end
    end else begin
      if (m > lim) begin
        val = {1'b0, {(ROOT_W-1){1'b1}}};
        ovf = 1'b1;
      end else begin
        val = m[ROOT_W-1:0];
      end
    end
    return {ovf, val};
  endfunction

endpackage

// ===== rtl/qrs_front.sv =====
module qrs_front import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COEF_W-1:0] in_a,
  input  logic signed [COEF_W-1:0] in_b,
  input  logic signed [COEF_W-1:0] in_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output qentry_t                  out_entry
);

  logic                       v1_r;
  logic signed [COEF_W-1:0]   a1_r, b1_r, c1_r;
  logic signed [2*COEF_W-1:0] bb1_r, ac1_r;
  logic                       v2_r;
  qentry_t                    ent2_r;
  qentry_t                    ent2_nxt;
  logic                       adv1, adv2;
  logic signed [DISC_W-1:0]   disc;

  // Advance a stage when it is empty or the next one moves
  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      a1_r  <= in_a;
      b1_r  <= in_b;
      c1_r  <= in_c;
      bb1_r <= in_b * in_b;
      ac1_r <= in_a * in_c;
    end
  end

  // Stage 2: discriminant and classification
  always_comb begin
    disc          = DISC_W'(bb1_r) - (DISC_W'(ac1_r) <<< 2);
    ent2_nxt.a    = a1_r;
    ent2_nxt.b    = b1_r;
    ent2_nxt.c    = c1_r;
    ent2_nxt.disc = disc;
    ent2_nxt.lin  = 1'b0;
    if (a1_r == '0) begin
      ent2_nxt.lin  = 1'b1;
      ent2_nxt.kind = (b1_r == '0) ? KIND_DEGEN : KIND_ONE;
    end else if (disc < 0) begin
      ent2_nxt.kind = KIND_NONE;
    end else if (disc == '0) begin
      ent2_nxt.kind = KIND_ONE;
    end else begin
      ent2_nxt.kind = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      ent2_r <= ent2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_entry = ent2_r;

endmodule

// ===== rtl/qrs_queue.sv =====
module qrs_queue import qrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  qentry_t push_entry,
  output logic    pop_valid,
  input  logic    pop_ready,
  output qentry_t pop_entry
);

  qentry_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/qrs_div.sv =====
module qrs_div import qrs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // One quotient bit per stage, restoring division
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar gi = 0; gi < NUM_W; gi++) begin : g_stage
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in, den_in;
    logic [DEN_W:0]   wide;
    logic             ge;

    if (gi == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign nq_in  = nq_r[gi-1];
      assign rem_in = rem_r[gi-1];
      assign den_in = den_r[gi-1];
    end

    assign wide = {rem_in, nq_in[NUM_W-1]};
    assign ge   = (wide >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[gi]  <= {nq_in[NUM_W-2:0], ge};
        rem_r[gi] <= ge ? DEN_W'(wide - {1'b0, den_in}) : DEN_W'(wide);
        den_r[gi] <= den_in;
      end
    end
  end

  assign quo = nq_r[NUM_W-1];

endmodule

// ===== rtl/qrs_back.sv =====
module qrs_back import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qentry_t           in_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [ROOT_W-1:0] out_first,
  output logic [ROOT_W-1:0] out_second,
  output logic              out_ovf
);

  logic en;

  // Stage 0 registers
  logic             b0_v_r;
  sq_side_t         b0_side_r;
  logic [RAD_W-1:0] b0_rad_r;

  // Square-root stages
  logic             sq_v_r    [SQ_W];
  sq_side_t         sq_side_r [SQ_W];
  logic [SQ_W:0]    sq_rem_r  [SQ_W];
  logic [SQ_W-1:0]  sq_root_r [SQ_W];
  logic [RAD_W-1:0] sq_rad_r  [SQ_W];

  // Divider setup stage
  logic             pr_v_r;
  dv_side_t         pr_side_r;
  logic [NUM_W-1:0] pr_n1_r, pr_n2_r;
  logic [DEN_W-1:0] pr_den_r;

  // Divider sideband
  logic             dv_v_r    [NUM_W];
  dv_side_t         dv_side_r [NUM_W];
  logic [NUM_W-1:0] q1, q2;

  // Output register
  logic              out_v_r;
  kind_t             out_kind_r;
  logic [ROOT_W-1:0] out_first_r, out_second_r;
  logic              out_ovf_r;

  // The whole pipeline moves when the output register frees
  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  // Stage 0: -b*256 and radicand disc << 16, zero for linear or rootless requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else if (en) begin
      b0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      b0_side_r.kind <= in_entry.kind;
      b0_side_r.lin  <= in_entry.lin;
      b0_side_r.a    <= in_entry.a;
      b0_side_r.b    <= in_entry.b;
      b0_side_r.c    <= in_entry.c;
      b0_side_r.nb   <= -(SUM_W'(in_entry.b) <<< 8);
      if (!in_entry.lin && (in_entry.kind == KIND_TWO || in_entry.kind == KIND_ONE)) begin
        b0_rad_r <= RAD_W'(in_entry.disc[DISC_W-2:0]) << 16;
      end else begin
        b0_rad_r <= '0;
      end
    end
  end

  // Floor square root, one result bit per stage
  for (genvar gi = 0; gi < SQ_W; gi++) begin : g_sq
    logic             v_in;
    sq_side_t         side_in;
    logic [SQ_W:0]    rem_in;
    logic [SQ_W-1:0]  root_in;
    logic [RAD_W-1:0] rad_in;
    logic [SQ_W+2:0]  wide, trial;
    logic             ge;

    if (gi == 0) begin : g_first
      assign v_in    = b0_v_r;
      assign side_in = b0_side_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = b0_rad_r;
    end else begin : g_next
      assign v_in    = sq_v_r[gi-1];
      assign side_in = sq_side_r[gi-1];
      assign rem_in  = sq_rem_r[gi-1];
      assign root_in = sq_root_r[gi-1];
      assign rad_in  = sq_rad_r[gi-1];
    end

    assign wide  = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (wide >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[gi] <= 1'b0;
      end else if (en) begin
        sq_v_r[gi] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[gi] <= side_in;
        sq_rem_r[gi]  <= ge ? (SQ_W+1)'(wide - trial) : (SQ_W+1)'(wide);
        sq_root_r[gi] <= {root_in[SQ_W-2:0], ge};
        sq_rad_r[gi]  <= rad_in << 2;
      end
    end
  end

  // Divider setup: signed dividends and divisor, split into sign and magnitude
  sq_side_t                 sqo;
  logic signed [SUM_W-1:0]  s_val, sum1, sum2;
  logic signed [NUM_W:0]    n1, n2;
  logic signed [DEN_W:0]    dn;

  assign sqo = sq_side_r[SQ_W-1];

  always_comb begin
    s_val = $signed(SUM_W'(sq_root_r[SQ_W-1]));
    sum1  = sqo.nb - s_val;
    sum2  = sqo.nb + s_val;
    if (sqo.lin) begin
      n1 = -((NUM_W+1)'(sqo.c) <<< 16);
      dn = (DEN_W+1)'(sqo.b);
    end else begin
      n1 = (NUM_W+1)'(sum1) <<< 8;
      dn = (DEN_W+1)'(sqo.a) <<< 1;
    end
    n2 = (NUM_W+1)'(sum2) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (en) begin
      pr_v_r <= sq_v_r[SQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_side_r.kind <= sqo.kind;
      pr_side_r.neg1 <= n1[NUM_W] ^ dn[DEN_W];
      pr_side_r.neg2 <= n2[NUM_W] ^ dn[DEN_W];
      pr_n1_r        <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
      pr_n2_r        <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
      pr_den_r       <= dn[DEN_W] ? DEN_W'(-dn) : DEN_W'(dn);
    end
  end

  // Two dividers share the divisor
  qrs_div u_div1 (
    .clk (clk),
    .en  (en),
    .num (pr_n1_r),
    .den (pr_den_r),
    .quo (q1)
  );

  qrs_div u_div2 (
    .clk (clk),
    .en  (en),
    .num (pr_n2_r),
    .den (pr_den_r),
    .quo (q2)
  );

  // Carry kind and signs beside the dividers
  for (genvar gi = 0; gi < NUM_W; gi++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[gi] <= 1'b0;
      end else if (en) begin
        dv_v_r[gi] <= (gi == 0) ? pr_v_r : dv_v_r[(gi == 0) ? 0 : gi-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[gi] <= (gi == 0) ? pr_side_r : dv_side_r[(gi == 0) ? 0 : gi-1];
      end
    end
  end

  // Sign, clamp and select the roots that the kind returns
  dv_side_t          dvo;
  logic [ROOT_W:0]   fit1, fit2;
  logic [ROOT_W-1:0] first_nxt, second_nxt;
  logic              ovf_nxt;

  assign dvo = dv_side_r[NUM_W-1];

  always_comb begin
    fit1       = fit_root(q1, dvo.neg1);
    fit2       = fit_root(q2, dvo.neg2);
    first_nxt  = '0;
    second_nxt = '0;
    ovf_nxt    = 1'b0;
    case (dvo.kind)
      KIND_TWO: begin
        first_nxt  = fit1[ROOT_W-1:0];
        second_nxt = fit2[ROOT_W-1:0];
        ovf_nxt    = fit1[ROOT_W] | fit2[ROOT_W];
      end
      KIND_ONE: begin
        first_nxt = fit1[ROOT_W-1:0];
        ovf_nxt   = fit1[ROOT_W];
      end
      default: begin
        first_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_v_r[NUM_W-1]) begin
      out_kind_r   <= dvo.kind;
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
      out_ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_kind   = out_kind_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_ovf    = out_ovf_r;

endmodule

// ===== rtl/quadratic_root_solver_unit.sv =====
// Real roots of a*x^2 + b*x + c = 0. Coefficients are signed Q8.8, roots
// signed Q16.16, truncated toward zero and clamped with an overflow flag.
// The unit takes one request per clock unless the queue is full, and returns
// one result per request in order. The path runs through two front stages
// (products, then discriminant and classification), the four-entry queue, a
// setup stage, 25 square-root stages, a divider setup stage, 35 divider
// stages and the output register. A stall on the result side holds the back
// pipeline while the queue and the front keep taking requests until the queue
// fills.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [3*COEF_W-1:0]   in_tdata,   // coef_a, coef_b, coef_c
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*ROOT_W-1:0]   out_tdata,  // root_first, root_second
  output logic [2:0]            out_tuser   // root_kind[1:0], range_overflow
);

  logic    fq_valid, fq_ready;
  qentry_t fq_entry;
  logic    qb_valid, qb_ready;
  qentry_t qb_entry;
  kind_t             kind;
  logic [ROOT_W-1:0] first, second;
  logic              ovf;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_a      ($signed(in_tdata[COEF_W-1:0])),
    .in_b      ($signed(in_tdata[2*COEF_W-1:COEF_W])),
    .in_c      ($signed(in_tdata[3*COEF_W-1:2*COEF_W])),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_entry (fq_entry)
  );

  qrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_entry (fq_entry),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_entry  (qb_entry)
  );

  qrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (qb_valid),
    .in_ready   (qb_ready),
    .in_entry   (qb_entry),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_first  (first),
    .out_second (second),
    .out_ovf    (ovf)
  );

  assign out_tdata = {second, first};
  assign out_tuser = {ovf, kind};

  // Only two distinct roots carry a second root
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind != KIND_TWO) |-> (second == '0))
    else $error("second root set without two distinct roots");

  // No real root means zero roots and no overflow
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind == KIND_NONE || kind == KIND_DEGEN) |->
      (first == '0) && !ovf)
    else $error("root or overflow set with no real root");

  // Overflow only comes with a clamped root
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf |->
      (first == {1'b0, {(ROOT_W-1){1'b1}}}) || (first == {1'b1, {(ROOT_W-1){1'b0}}}) ||
      (second == {1'b0, {(ROOT_W-1){1'b1}}}) || (second == {1'b1, {(ROOT_W-1){1'b0}}}))
    else $error("overflow flag without a clamped root");

endmodule
